@@ rtl/dq_pkg.sv @@
package dq_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int CNT_W  = 5;

    localparam int IN_W   = 40;
    localparam int OUT_W  = 112;

    localparam logic [2:0] MODE_PUSH_BACK  = 3'd0;
    localparam logic [2:0] MODE_PUSH_FRONT = 3'd1;
    localparam logic [2:0] MODE_POP_BACK   = 3'd2;
    localparam logic [2:0] MODE_POP_FRONT  = 3'd3;
    localparam logic [2:0] MODE_READ       = 3'd4;
    localparam logic [2:0] MODE_WRITE      = 3'd5;
    localparam logic [2:0] MODE_INSERT     = 3'd6;
    localparam logic [2:0] MODE_ERASE      = 3'd7;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    localparam logic [1:0] OP_HOLD  = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_LEFT  = 2'd2;
    localparam logic [1:0] OP_RIGHT = 2'd3;

    typedef struct packed {
        logic [1:0] op;
        logic       rd_sel;
        logic       back_sel;
    } t_cell_ctl;

endpackage

@@ rtl/dq_cell.sv @@
module dq_cell (
    input  logic                      i_clk,
    input  dq_pkg::t_cell_ctl         i_ctl,
    input  logic [dq_pkg::DATA_W-1:0] i_value,
    input  logic [dq_pkg::DATA_W-1:0] i_left,
    input  logic [dq_pkg::DATA_W-1:0] i_right,
    output logic [dq_pkg::DATA_W-1:0] o_data,
    output logic [dq_pkg::DATA_W-1:0] o_next,
    output logic [dq_pkg::DATA_W-1:0] o_rd_term,
    output logic [dq_pkg::DATA_W-1:0] o_back_term
);
    import dq_pkg::*;

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;

    always_comb begin
        unique case (i_ctl.op)
            OP_LOAD:  n_data = i_value;
            OP_LEFT:  n_data = i_left;
            OP_RIGHT: n_data = i_right;
            default:  n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data      = r_data;
    assign o_next      = n_data;
    assign o_rd_term   = i_ctl.rd_sel   ? r_data : '0;
    assign o_back_term = i_ctl.back_sel ? n_data : '0;

endmodule

@@ rtl/double_ended_queue_shifting.sv @@
// Results are registered from their requests. Throughput: one request per
// cycle unless the sink stalls a held result; every cell shifts, loads or
// holds in parallel, so a gap opens or closes as the request is taken.
// Reset (synchronous, active low) empties the deque and drops the pending
// result; cell contents are not cleared.
module double_ended_queue_shifting (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    // mode[2:0], index[7:3], value[39:8]
    input  logic [dq_pkg::IN_W-1:0]  i_s_axis_tdata,
    output logic                     o_m_axis_tvalid,
    input  logic                     i_m_axis_tready,
    // status[1:0], read_value[33:2], front_value[65:34], back_value[97:66],
    // entry_count[102:98], position[107:103], zero[111:108]
    output logic [dq_pkg::OUT_W-1:0] o_m_axis_tdata
);
    import dq_pkg::*;

    logic              w_accept;
    logic [2:0]        w_mode;
    logic [CNT_W-1:0]  w_idx;
    logic [DATA_W-1:0] w_val;

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_out_valid;
    logic [1:0]        r_status;
    logic [31:0]       r_rd;
    logic [31:0]       r_front;
    logic [31:0]       r_back;
    logic [CNT_W-1:0]  r_out_count;
    logic [CNT_W-1:0]  r_pos;

    logic [1:0]        w_status;
    logic              w_open;
    logic              w_close;
    logic              w_load;
    logic              w_rd_en;
    logic [CNT_W-1:0]  w_at;
    logic [CNT_W-1:0]  w_pos;

    t_cell_ctl         w_ctl       [DEPTH];
    logic [DATA_W-1:0] w_data      [DEPTH];
    logic [DATA_W-1:0] w_next      [DEPTH];
    logic [DATA_W-1:0] w_rd_term   [DEPTH];
    logic [DATA_W-1:0] w_back_term [DEPTH];
    logic [DEPTH-1:0]  w_back_sel;
    logic [DATA_W-1:0] w_rd_or;
    logic [DATA_W-1:0] w_back_or;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_mode          = i_s_axis_tdata[2:0];
    assign w_idx           = i_s_axis_tdata[7:3];
    assign w_val           = i_s_axis_tdata[8 +: DATA_W];

    always_comb begin
        w_status = ST_OK;
        w_open   = 1'b0;
        w_close  = 1'b0;
        w_load   = 1'b0;
        w_rd_en  = 1'b0;
        w_at     = '0;
        w_pos    = '0;
        n_count  = r_count;
        unique case (w_mode)
            MODE_PUSH_BACK, MODE_PUSH_FRONT: begin
                if (r_count >= CNT_W'(DEPTH)) begin
                    w_status = ST_FULL;
                end else begin
                    w_open  = 1'b1;
                    w_at    = (w_mode == MODE_PUSH_BACK) ? r_count : '0;
                    n_count = r_count + 1'b1;
                end
            end
            MODE_POP_BACK, MODE_POP_FRONT: begin
                if (r_count == '0) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_close = 1'b1;
                    w_rd_en = 1'b1;
                    w_at    = (w_mode == MODE_POP_BACK) ? r_count - 1'b1 : '0;
                    n_count = r_count - 1'b1;
                end
            end
            MODE_READ: begin
                if (w_idx >= r_count) begin
                    w_status = ST_RANGE;
                end else begin
                    w_rd_en = 1'b1;
                    w_at    = w_idx;
                end
            end
            MODE_WRITE: begin
                if (w_idx >= r_count) begin
                    w_status = ST_RANGE;
                end else begin
                    w_load = 1'b1;
                    w_at   = w_idx;
                end
            end
            MODE_INSERT: begin
                if (w_idx > r_count) begin
                    w_status = ST_RANGE;
                end else if (r_count >= CNT_W'(DEPTH)) begin
                    w_status = ST_FULL;
                end else begin
                    w_open  = 1'b1;
                    w_at    = w_idx;
                    w_pos   = w_idx;
                    n_count = r_count + 1'b1;
                end
            end
            default: begin
                if (w_idx >= r_count) begin
                    w_status = ST_RANGE;
                end else begin
                    w_close = 1'b1;
                    w_at    = w_idx;
                    w_pos   = w_idx;
                    n_count = r_count - 1'b1;
                end
            end
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            localparam logic [CNT_W-1:0] CI = CNT_W'(g);
            logic [DATA_W-1:0] w_left;
            logic [DATA_W-1:0] w_right;

            if (g == 0) begin : g_first
                assign w_left = '0;
            end else begin : g_mid_l
                assign w_left = w_data[g-1];
            end
            if (g == DEPTH-1) begin : g_last
                assign w_right = '0;
            end else begin : g_mid_r
                assign w_right = w_data[g+1];
            end

            always_comb begin
                w_ctl[g].op = OP_HOLD;
                if (w_accept) begin
                    if (w_open) begin
                        if (CI == w_at) begin
                            w_ctl[g].op = OP_LOAD;
                        end else if (CI > w_at && CI <= r_count) begin
                            w_ctl[g].op = OP_LEFT;
                        end
                    end else if (w_close) begin
                        if (CI >= w_at && (CI + 1'b1) < r_count) begin
                            w_ctl[g].op = OP_RIGHT;
                        end
                    end else if (w_load && CI == w_at) begin
                        w_ctl[g].op = OP_LOAD;
                    end
                end
                w_ctl[g].rd_sel   = w_rd_en && (CI == w_at);
                w_ctl[g].back_sel = (n_count != '0) && (CI == n_count - 1'b1);
            end

            assign w_back_sel[g] = w_ctl[g].back_sel;

            dq_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl[g]),
                .i_value     (w_val),
                .i_left      (w_left),
                .i_right     (w_right),
                .o_data      (w_data[g]),
                .o_next      (w_next[g]),
                .o_rd_term   (w_rd_term[g]),
                .o_back_term (w_back_term[g])
            );
        end
    endgenerate

    always_comb begin
        w_rd_or   = '0;
        w_back_or = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_rd_or   = w_rd_or | w_rd_term[i];
            w_back_or = w_back_or | w_back_term[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count <= n_count;
            end
            if (o_s_axis_tready) begin
                r_out_valid <= i_s_axis_tvalid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status    <= w_status;
            r_rd        <= 32'(w_rd_or);
            r_front     <= (n_count != '0) ? 32'(w_next[0]) : '0;
            r_back      <= 32'(w_back_or);
            r_out_count <= n_count;
            r_pos       <= w_pos;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'b0, r_pos, r_out_count, r_back, r_front, r_rd, r_status};

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("element count above depth");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_status == ST_OK &&
        (w_mode == MODE_PUSH_BACK || w_mode == MODE_PUSH_FRONT)
        |=> r_count == $past(r_count) + 1'b1)
        else $error("push did not grow the count");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_status == ST_EMPTY |-> r_out_count == '0)
        else $error("empty status with nonzero count");

    a_back_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_back_sel))
        else $error("more than one back cell selected");

    a_out_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_out_count == r_count)
        else $error("result count differs from state");

endmodule

@@ bench/double_ended_queue_shifting_test.sv @@
`timescale 1ns / 1ps

module double_ended_queue_shifting_test;
    import dq_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int RANDOM_ITEMS = 400;

    typedef struct packed {
        logic [3:0]        pad;
        logic [CNT_W-1:0]  position;
        logic [CNT_W-1:0]  entry_count;
        logic [DATA_W-1:0] back_value;
        logic [DATA_W-1:0] front_value;
        logic [DATA_W-1:0] read_value;
        logic [1:0]        status;
    } t_deque_result;

    class t_deque_mirror;
        logic [DATA_W-1:0] cells [DEPTH];
        int unsigned       held;
        t_deque_result     results_due [$];
        int unsigned       failures;

        function new();
            held = 0;
            failures = 0;
        endfunction

        function void shift_up(int unsigned at);
            for (int unsigned i = held; i > at; i--) cells[i] = cells[i - 1];
        endfunction

        function void shift_down(int unsigned at);
            for (int unsigned i = at; i + 1 < held; i++) cells[i] = cells[i + 1];
        endfunction

        function void apply_request(logic [2:0] mode, logic [4:0] idx, logic [DATA_W-1:0] val);
            t_deque_result r;
            int unsigned at;
            r = '0;
            r.status = ST_OK;
            case (mode)
                MODE_PUSH_BACK, MODE_PUSH_FRONT: begin
                    if (held >= DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        at = (mode == MODE_PUSH_BACK) ? held : 0;
                        shift_up(at);
                        cells[at] = val;
                        held++;
                    end
                end
                MODE_POP_BACK, MODE_POP_FRONT: begin
                    if (held == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        at = (mode == MODE_POP_BACK) ? held - 1 : 0;
                        r.read_value = cells[at];
                        shift_down(at);
                        held--;
                    end
                end
                MODE_READ: begin
                    if (idx >= held) r.status = ST_RANGE;
                    else r.read_value = cells[idx];
                end
                MODE_WRITE: begin
                    if (idx >= held) r.status = ST_RANGE;
                    else cells[idx] = val;
                end
                MODE_INSERT: begin
                    if (idx > held) begin
                        r.status = ST_RANGE;
                    end else if (held >= DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        shift_up(idx);
                        cells[idx] = val;
                        held++;
                        r.position = idx;
                    end
                end
                default: begin
                    if (idx >= held) begin
                        r.status = ST_RANGE;
                    end else begin
                        shift_down(idx);
                        held--;
                        r.position = idx;
                    end
                end
            endcase
            if (held > 0) begin
                r.front_value = cells[0];
                r.back_value = cells[held - 1];
            end
            r.entry_count = held[CNT_W-1:0];
            results_due.insert(results_due.size(), r);
        endfunction

        function void compare_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
            if (got !== want) begin
                $error("%s: expected %h, got %h", name, want, got);
                failures++;
            end
        endfunction

        function void check_result(t_deque_result got);
            t_deque_result want;
            if (results_due.size() == 0) begin
                $error("unexpected result transaction: %h", got);
                failures++;
                return;
            end
            want = results_due[0];
            results_due.delete(0);
            compare_field("status", DATA_W'(want.status), DATA_W'(got.status));
            compare_field("read_value", want.read_value, got.read_value);
            compare_field("front_value", want.front_value, got.front_value);
            compare_field("back_value", want.back_value, got.back_value);
            compare_field("entry_count", DATA_W'(want.entry_count), DATA_W'(got.entry_count));
            compare_field("position", DATA_W'(want.position), DATA_W'(got.position));
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic [IN_W-1:0]   s_tdata = '0;
    logic              s_tready;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;

    int unsigned       src_idle_pct = 25;
    int unsigned       sink_idle_pct = 51;
    int unsigned       stall_cycles = 0;
    t_deque_mirror     mirror = new();

    double_ended_queue_shifting dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // result check and stall watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_tvalid && m_tready) mirror.check_result(t_deque_result'(m_tdata));
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    task automatic send_req(input logic [2:0] mode, input logic [4:0] idx,
                            input logic [DATA_W-1:0] val);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {val, idx, mode};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        mirror.apply_request(mode, idx, val);
    endtask

    task automatic churn(input int unsigned items);
        logic [2:0] grow_ops [3] = '{MODE_PUSH_BACK, MODE_PUSH_FRONT, MODE_INSERT};
        logic [2:0] shrink_ops [3] = '{MODE_POP_BACK, MODE_POP_FRONT, MODE_ERASE};
        int unsigned grow_pct;
        int unsigned r;
        logic [2:0] mode;
        logic [4:0] idx;
        grow_pct = 50;
        for (int unsigned n = 0; n < items; n++) begin
            // drift toward full or empty in stretches
            if (n % 40 == 0) grow_pct = 25 * $urandom_range(1, 3);
            r = $urandom_range(0, 99);
            if (r < 5) mode = 3'($urandom_range(0, 7));
            else if (r < grow_pct) mode = grow_ops[$urandom_range(0, 2)];
            else if (r < grow_pct + (100 - grow_pct) * 2 / 3) mode = shrink_ops[$urandom_range(0, 2)];
            else mode = $urandom_range(0, 1) ? MODE_READ : MODE_WRITE;
            if ($urandom_range(0, 99) < 85) idx = 5'($urandom_range(0, mirror.held));
            else idx = 5'($urandom_range(0, 31));
            send_req(mode, idx, $urandom());
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty deque
        send_req(MODE_POP_BACK, 5'd0, 32'h0);
        send_req(MODE_POP_FRONT, 5'd0, 32'h0);
        send_req(MODE_ERASE, 5'd0, 32'h0);
        send_req(MODE_READ, 5'd0, 32'h0);
        send_req(MODE_WRITE, 5'd0, 32'hFFFF_FFFF);
        send_req(MODE_INSERT, 5'd1, 32'h1);
        send_req(MODE_INSERT, 5'd0, 32'hFFFF_FFFF);
        send_req(MODE_PUSH_BACK, 5'd31, 32'h0);
        send_req(MODE_PUSH_FRONT, 5'd0, 32'hA5A5_5A5A);
        send_req(MODE_INSERT, 5'd3, 32'h8000_0001);
        send_req(MODE_INSERT, 5'd2, 32'h1234_5678);
        send_req(MODE_READ, 5'd31, 32'h0);
        send_req(MODE_READ, 5'd0, 32'h0);
        send_req(MODE_WRITE, 5'd4, 32'h5A5A_A5A5);
        send_req(MODE_READ, 5'd4, 32'h0);
        send_req(MODE_ERASE, 5'd4, 32'h0);
        send_req(MODE_ERASE, 5'd1, 32'h0);
        send_req(MODE_ERASE, 5'd3, 32'h0);
        send_req(MODE_POP_BACK, 5'd0, 32'h0);
        send_req(MODE_POP_FRONT, 5'd0, 32'h0);

        // fill, then full deque
        while (mirror.held < DEPTH) send_req(MODE_PUSH_BACK, 5'd0, $urandom());
        send_req(MODE_PUSH_BACK, 5'd0, 32'hDEAD_0001);
        send_req(MODE_PUSH_FRONT, 5'd0, 32'hDEAD_0002);
        send_req(MODE_INSERT, 5'd16, 32'hDEAD_0003);
        send_req(MODE_INSERT, 5'd17, 32'hDEAD_0004);
        send_req(MODE_READ, 5'd15, 32'h0);
        send_req(MODE_WRITE, 5'd16, 32'h0);
        send_req(MODE_ERASE, 5'd16, 32'h0);
        send_req(MODE_POP_FRONT, 5'd0, 32'h0);
        send_req(MODE_INSERT, 5'd0, 32'h0000_FFFF);

        churn(RANDOM_ITEMS);
        src_idle_pct = 51;
        sink_idle_pct = 25;
        churn(RANDOM_ITEMS);
        src_idle_pct = 0;
        sink_idle_pct = 0;
        churn(RANDOM_ITEMS);

        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (mirror.results_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (mirror.failures == 0 && mirror.results_due.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/dq_pkg.sv
rtl/dq_cell.sv
rtl/double_ended_queue_shifting.sv
bench/double_ended_queue_shifting_test.sv
